/* rtl/core/tabular_block_line_deframer_unit_defines.svh */
// Assertion macros shared by the tabular block line deframer RTL.
// Needs nothing else; the files that check their own logic include it.
`ifndef TABULAR_BLOCK_LINE_DEFRAMER_UNIT_DEFINES_SVH
`define TABULAR_BLOCK_LINE_DEFRAMER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBLD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tbld_pkg.sv */
// Types and constants of the tabular block line deframer.
// No dependencies; used by every module of the block.
package tbld_pkg;

    // Input word: one byte of the block and the block start flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_start;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  text_char;
        logic        line_end;
        logic [14:0] page_index;
    } t_out_word;

    // Status of the result queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Result kinds.
    localparam logic [2:0] KIND_TEXT        = 3'd0;
    localparam logic [2:0] KIND_EMPTY       = 3'd1;
    localparam logic [2:0] KIND_BAD_DIVIDER = 3'd2;
    localparam logic [2:0] KIND_BAD_ID      = 3'd3;
    localparam logic [2:0] KIND_BAD_LEN     = 3'd4;

    // Block layout.
    localparam int unsigned HDR_SKIP    = 120;
    localparam int unsigned DIVIDER_GAP = 8;
    localparam logic [31:0] PAGE_CNT_LAST = 32'(DIVIDER_GAP + HDR_SKIP + 3);
    localparam logic [15:0] BLOCK_ID    = 16'd3;
    localparam logic [15:0] DIVIDER     = 16'hFFFF;
    localparam logic [14:0] PAGE_MAX    = 15'h7FFF;

endpackage

/* rtl/core/tbld_front.sv */
// Front end: header and record parser that turns each accepted byte into
// at most one result word. Depends on tbld_pkg.
module tbld_front
    import tbld_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_word  i_item,
    output logic      o_res_valid,
    output t_out_word o_res
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_TEXT   = 3'd4,
        PH_IDLE   = 3'd5
    } t_phase;

    // Header offsets at which the low byte of a field arrives.
    localparam logic [31:0] OFF_DIVIDER_LO = 32'd1;
    localparam logic [31:0] OFF_ID_LO      = 32'd3;
    localparam logic [31:0] OFF_LEN_LO     = 32'd7;

    t_phase      r_phase, n_phase, e_phase;
    logic [31:0] r_off, n_off, e_off;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_blen, n_blen;
    logic [14:0] r_ptot, n_ptot;
    logic [14:0] r_pc, n_pc, e_pc;
    logic [14:0] r_cl, n_cl;
    logic [15:0] half;
    logic        bs;

    // Next-state and result decode for the byte on the input.
    always_comb begin
        bs      = i_item.block_start;
        e_phase = bs ? PH_HEADER : r_phase;
        e_off   = bs ? '0 : r_off;
        e_pc    = bs ? '0 : r_pc;
        n_shift = {(bs ? 24'd0 : r_shift[23:0]), i_item.data_byte};
        half    = n_shift[15:0];

        n_phase = e_phase;
        n_blen  = bs ? '0 : r_blen;
        n_ptot  = bs ? '0 : r_ptot;
        n_pc    = e_pc;
        n_cl    = bs ? '0 : r_cl;

        o_res_valid      = 1'b0;
        o_res.kind       = KIND_TEXT;
        o_res.text_char  = 8'd0;
        o_res.line_end   = 1'b0;
        o_res.page_index = e_pc;

        case (e_phase)
            PH_HEADER: begin
                if (e_off == OFF_DIVIDER_LO && half != DIVIDER) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_BAD_DIVIDER;
                    n_phase     = PH_IDLE;
                end else if (e_off == OFF_ID_LO && half != BLOCK_ID) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_BAD_ID;
                    n_phase     = PH_IDLE;
                end else if (e_off == OFF_LEN_LO) begin
                    n_blen  = n_shift;
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (e_off >= PAGE_CNT_LAST) begin
                    // A negative page count means no pages.
                    n_ptot  = half[15] ? '0 : half[14:0];
                    n_pc    = '0;
                    n_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                // Records stop after the last page or at the block length.
                if (e_pc >= n_ptot ||
                    $signed({1'b0, e_off}) >= $signed({n_blen[31], n_blen})) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                if (half == DIVIDER) begin
                    if (e_pc < PAGE_MAX) begin
                        n_pc = e_pc + 15'd1;
                    end
                    n_phase = PH_LEN_HI;
                end else if (half[15]) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_BAD_LEN;
                    n_phase     = PH_IDLE;
                end else if (half == 16'd0) begin
                    o_res_valid    = 1'b1;
                    o_res.kind     = KIND_EMPTY;
                    o_res.line_end = 1'b1;
                    n_phase        = PH_LEN_HI;
                end else begin
                    n_cl    = half[14:0];
                    n_phase = PH_TEXT;
                end
            end
            PH_TEXT: begin
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_TEXT;
                o_res.text_char = i_item.data_byte;
                o_res.line_end  = (n_cl <= 15'd1);
                if (n_cl <= 15'd1) begin
                    n_cl    = '0;
                    n_phase = PH_LEN_HI;
                end else begin
                    n_cl = n_cl - 15'd1;
                end
            end
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // Offset counter saturates at all ones.
        n_off = (e_off == '1) ? e_off : e_off + 32'd1;
    end

    // Parser state, updated on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_off   <= '0;
            r_shift <= '0;
            r_blen  <= '0;
            r_ptot  <= '0;
            r_pc    <= '0;
            r_cl    <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_shift <= n_shift;
            r_blen  <= n_blen;
            r_ptot  <= n_ptot;
            r_pc    <= n_pc;
            r_cl    <= n_cl;
        end
    end

endmodule

/* rtl/core/tbld_queue.sv */
// Back end: short result queue between the parser and the consumer.
// Depends on tbld_pkg.
module tbld_queue
    import tbld_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_word,
    input  logic      i_pop,
    output t_out_word o_head,
    output t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_out_word        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    // Handshake qualification and pointer arithmetic.
    always_comb begin
        o_status.full  = (r_count == CNT_FULL);
        o_status.empty = (r_count == '0);
        do_push  = i_push && !o_status.full;
        do_pop   = i_pop && !o_status.empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign o_head = r_mem[r_rd_ptr];

    // Storage for waiting words.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/core/tabular_block_line_deframer_unit.sv */
// Tabular block line deframer: parser front end feeding a result queue.
// Takes one byte per cycle unless full; results are queued and popped in byte order.
// The byte rate is limited only by queue space: full rises when QUEUE_DEPTH words wait.
// Synchronous active-low reset empties the queue and sets the parser to expect a header.
// Depends on tbld_pkg, tbld_front, tbld_queue and the assertion macro header.
`include "tabular_block_line_deframer_unit_defines.svh"
module tabular_block_line_deframer_unit
    import tbld_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_result
);

    logic      accept;
    logic      res_valid;
    t_out_word res_word;
    t_q_status q_status;

    // A byte is taken whenever the queue has room for its result.
    assign accept = push && !q_status.full;
    assign full   = q_status.full;
    assign empty  = q_status.empty;

    tbld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_res_valid (res_valid),
        .o_res       (res_word)
    );

    tbld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept && res_valid),
        .i_word   (res_word),
        .i_pop    (pop),
        .o_head   (o_result),
        .o_status (q_status)
    );

    // Checks on the parser and queue.
    `TBLD_ASSERT_SAME(a_full_not_empty, i_clk, i_rst_n, full, !empty, "queue full and empty")
    `TBLD_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, accept && res_valid, !empty, "result lost")
    `TBLD_ASSERT_SAME(a_kind_range, i_clk, i_rst_n, !empty, o_result.kind <= KIND_BAD_LEN, "bad kind")
    `TBLD_ASSERT_SAME(a_error_fields, i_clk, i_rst_n,
        !empty && o_result.kind != KIND_TEXT && o_result.kind != KIND_EMPTY,
        !o_result.line_end && o_result.text_char == 8'd0, "error word fields")

endmodule
